// ----- design/sjisr_pkg.sv -----
package sjisr_pkg;

  localparam int unsigned MAX_MATCH_BYTES_DEF   = 16;
  localparam int unsigned MAX_REPLACE_BYTES_DEF = 16;
  localparam int unsigned REG_BYTES             = 16;
  localparam int unsigned QUEUE_DEPTH           = 4;

  localparam logic [7:0] LEAD_LOW        = 8'd129;
  localparam logic [7:0] LEAD_HIGH_END   = 8'd159;
  localparam logic [7:0] LEAD_HIGH_START = 8'd224;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_MATCH_LOW    = 3'd0,
    REG_MATCH_HIGH   = 3'd1,
    REG_MATCH_LENGTH = 3'd2,
    REG_REPLACE_LOW  = 3'd3,
    REG_REPLACE_HIGH = 3'd4,
    REG_REPLACE_LEN  = 3'd5
  } reg_index_e;

  typedef enum logic {
    CMD_PASS = 1'b0,
    CMD_REPL = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] replace_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] match_low_bytes;
    logic [63:0] match_high_bytes;
    logic [4:0]  match_length;
    logic [63:0] replace_low_bytes;
    logic [63:0] replace_high_bytes;
    logic [4:0]  replace_length;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] count;
  } cmd_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= LEAD_LOW) && ((b <= LEAD_HIGH_END) || (b >= LEAD_HIGH_START));
  endfunction

endpackage

// ----- design/sjisr_front.sv -----
module sjisr_front
  import sjisr_pkg::*;
#(
  parameter int unsigned MAX_MATCH_BYTES = MAX_MATCH_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  localparam int unsigned WIN   = (MAX_MATCH_BYTES < REG_BYTES) ? MAX_MATCH_BYTES : REG_BYTES;
  localparam int unsigned LEN_W = $clog2(WIN + 1);

  logic [7:0]       win_q [WIN];
  logic [7:0]       win_d [WIN];
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             pend_q, pend_d;
  logic             end_q, end_d;
  logic [15:0]      cnt_q, cnt_d;

  logic [127:0]     match_all;
  logic [4:0]       eff_len;
  logic             all_eq;
  logic             act_need;
  logic             act;
  logic             accept;
  logic             match;
  logic             last;
  logic [LEN_W-1:0] fill_after;
  logic [15:0]      cnt_inc;

  assign match_all = {cfg_i.match_high_bytes, cfg_i.match_low_bytes};

  always_comb begin
    eff_len = cfg_i.match_length;
    if (eff_len == 5'd0) begin
      eff_len = 5'd1;
    end
    if (eff_len > 5'(REG_BYTES)) begin
      eff_len = 5'(REG_BYTES);
    end
    if (eff_len > 5'(WIN)) begin
      eff_len = 5'(WIN);
    end
  end

  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      if ((LEN_W'(i) < len_q) && (win_q[i] != match_all[8*i +: 8])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign act_need   = (fill_q != '0) && (pend_q || (fill_q >= len_q) || end_q);
  assign in_ready_o = !act_need;
  assign accept     = in_valid_i && !act_need;
  assign act        = act_need && cmd_ready_i;
  assign match      = !pend_q && (fill_q >= len_q) && all_eq;
  assign fill_after = match ? '0 : fill_q - LEN_W'(1);
  assign last       = end_q && (fill_after == '0);
  assign cnt_inc    = (match && (cnt_q != COUNT_MAX)) ? cnt_q + 16'd1 : cnt_q;

  assign cmd_valid_o = act_need;
  always_comb begin
    cmd_o.kind  = match ? CMD_REPL : CMD_PASS;
    cmd_o.data  = win_q[0];
    cmd_o.last  = last;
    cmd_o.count = last ? cnt_inc : 16'd0;
  end

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    len_d  = len_q;
    pend_d = pend_q;
    end_d  = end_q;
    cnt_d  = cnt_q;
    if (accept) begin
      for (int i = 0; i < WIN; i++) begin
        if (fill_q == LEN_W'(i)) begin
          win_d[i] = in_item_i.source_byte;
        end
      end
      fill_d = fill_q + LEN_W'(1);
      end_d  = in_item_i.end_of_text;
      if (fill_q == '0) begin
        len_d = LEN_W'(eff_len);
      end
    end else if (act) begin
      for (int i = 0; i < WIN - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      fill_d = fill_after;
      pend_d = !pend_q && !match && is_lead(win_q[0]);
      cnt_d  = cnt_inc;
      if (last) begin
        pend_d = 1'b0;
        end_d  = 1'b0;
        cnt_d  = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= LEN_W'(1);
      pend_q <= 1'b0;
      end_q  <= 1'b0;
      cnt_q  <= 16'd0;
    end else begin
      fill_q <= fill_d;
      len_q  <= len_d;
      pend_q <= pend_d;
      end_q  <= end_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- design/sjisr_queue.sv -----
module sjisr_queue
  import sjisr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/sjisr_back.sv -----
module sjisr_back
  import sjisr_pkg::*;
#(
  parameter int unsigned MAX_REPLACE_BYTES = MAX_REPLACE_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_item_o
);

  localparam int unsigned RW    = (MAX_REPLACE_BYTES < REG_BYTES) ? MAX_REPLACE_BYTES : REG_BYTES;
  localparam int unsigned IDX_W = (RW > 1) ? $clog2(RW) : 1;

  cmd_t             cmd_q;
  logic             cmd_v_q, cmd_v_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_v_q, out_v_d;
  out_item_t        out_q;

  logic [127:0]     rep_all;
  logic [4:0]       rep_len;
  logic [6:0]       rep_off;
  out_item_t        item;
  logic             gen;
  logic             fin;
  logic             skip;
  logic             load;
  logic             done;

  assign rep_all = {cfg_i.replace_high_bytes, cfg_i.replace_low_bytes};
  assign rep_off = 7'(idx_q) << 3;

  always_comb begin
    rep_len = cfg_i.replace_length;
    if (rep_len > 5'(REG_BYTES)) begin
      rep_len = 5'(REG_BYTES);
    end
    if (rep_len > 5'(RW)) begin
      rep_len = 5'(RW);
    end
  end

  always_comb begin
    item.out_valid = 1'b1;
    item.out_byte  = cmd_q.data;
    item.out_last  = cmd_q.last;
    gen            = cmd_v_q;
    fin            = 1'b1;
    unique case (cmd_q.kind)
      CMD_PASS: begin
        fin = 1'b1;
      end
      CMD_REPL: begin
        if (rep_len == 5'd0) begin
          gen            = cmd_v_q && cmd_q.last;
          item.out_valid = 1'b0;
          item.out_byte  = 8'd0;
        end else begin
          item.out_byte = rep_all[rep_off +: 8];
          fin           = (5'(idx_q) == rep_len - 5'd1);
          item.out_last = cmd_q.last && fin;
        end
      end
      default: begin
        gen = 1'b0;
      end
    endcase
    item.replace_count = item.out_last ? cmd_q.count : 16'd0;
  end

  assign skip        = cmd_v_q && (cmd_q.kind == CMD_REPL) && (rep_len == 5'd0) && !cmd_q.last;
  assign load        = gen && (!out_v_q || res_ready_i);
  assign done        = (load && fin) || skip;
  assign cmd_ready_o = !cmd_v_q || done;

  always_comb begin
    cmd_v_d = cmd_v_q;
    idx_d   = idx_q;
    if (done) begin
      idx_d = '0;
    end else if (load) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_ready_o) begin
      cmd_v_d = cmd_valid_i;
    end
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
    end else if (res_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (load) begin
      out_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_v_q <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      cmd_v_q <= cmd_v_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_item_o  = out_q;

endmodule

// ----- design/sjis_stream_replace_top.sv -----
// A source byte passes the front window, the request queue, the back command register and the
// output register. The front takes no new source byte while its window append/decide step has a
// decision pending. The back emits a replacement burst one byte per result, and the end flush
// passes the bytes left in the window one at a time; a 4-entry request queue separates the two.
// Reset: asynchronous, active low; clears control state, the replacement count and all
// configuration registers to their reset values. Window contents stay undefined until written.
module sjis_stream_replace_top
  import sjisr_pkg::*;
#(
  parameter int unsigned MAX_MATCH_BYTES   = MAX_MATCH_BYTES_DEF,
  parameter int unsigned MAX_REPLACE_BYTES = MAX_REPLACE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output out_item_t  res_item_o
);

  cfg_t cfg_q;
  logic q_push_valid;
  logic q_push_ready;
  cmd_t q_push_cmd;
  logic q_pop_valid;
  logic q_pop_ready;
  cmd_t q_pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_low_bytes    <= 64'd0;
      cfg_q.match_high_bytes   <= 64'd0;
      cfg_q.match_length       <= 5'd1;
      cfg_q.replace_low_bytes  <= 64'd0;
      cfg_q.replace_high_bytes <= 64'd0;
      cfg_q.replace_length     <= 5'd0;
    end else if (cfg_we_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_MATCH_LOW:    cfg_q.match_low_bytes    <= cfg_wdata_i;
        REG_MATCH_HIGH:   cfg_q.match_high_bytes   <= cfg_wdata_i;
        REG_MATCH_LENGTH: cfg_q.match_length       <= cfg_wdata_i[4:0];
        REG_REPLACE_LOW:  cfg_q.replace_low_bytes  <= cfg_wdata_i;
        REG_REPLACE_HIGH: cfg_q.replace_high_bytes <= cfg_wdata_i;
        REG_REPLACE_LEN:  cfg_q.replace_length     <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  sjisr_front #(
    .MAX_MATCH_BYTES(MAX_MATCH_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cmd_valid_o(q_push_valid),
    .cmd_ready_i(q_push_ready),
    .cmd_o      (q_push_cmd)
  );

  sjisr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(q_push_valid),
    .push_ready_o(q_push_ready),
    .push_cmd_i  (q_push_cmd),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_cmd_o   (q_pop_cmd)
  );

  sjisr_back #(
    .MAX_REPLACE_BYTES(MAX_REPLACE_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(q_pop_valid),
    .cmd_ready_o(q_pop_ready),
    .cmd_i      (q_pop_cmd),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready_i),
    .res_item_o (res_item_o)
  );

endmodule

// ----- bench/sjis_stream_replace_top_test.sv -----
module sjis_stream_replace_top_test
  import sjisr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LONG_HOLD     = 500;
  localparam int unsigned HOLD_AFTER    = 60;
  localparam int unsigned RANDOM_ITEMS  = 250;
  localparam int unsigned PHASE_ITEMS   = 28;
  localparam int unsigned WINDOW_DEPTH  = MAX_MATCH_BYTES_DEF;
  localparam logic [2:0]  REG_UNMAPPED  = 3'd6;

  typedef enum logic {
    ROW_REQ,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    in_item_t    req;
    logic        typed;
    out_item_t   want;
    logic [2:0]  reg_idx;
    logic [63:0] reg_val;
  } plan_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        res_valid_o;
  logic        res_ready_i = 1'b0;
  out_item_t   res_item_o;

  sjis_stream_replace_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_item_o  (res_item_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block's registers and text state
  cfg_t        regs_now;
  logic [7:0]  win [WINDOW_DEPTH];
  int unsigned win_fill;
  int unsigned latched_len;
  int unsigned repl_total;
  logic        pass_next;

  out_item_t   step_out [$];
  out_item_t   awaited_q [$];
  plan_row_t   plan_q [$];

  logic        failed      = 1'b0;
  logic        hold_wanted = 1'b0;
  logic        send_calm   = 1'b0;
  logic        take_calm   = 1'b0;
  int unsigned cycle_count;

  function automatic logic [7:0] pick_byte(logic [63:0] lo, logic [63:0] hi, int unsigned k);
    if (k < 8) return lo[8*k +: 8];
    return hi[8*(k-8) +: 8];
  endfunction

  function automatic int unsigned eff_match_len();
    int unsigned m;
    m = 32'(regs_now.match_length);
    if (m < 1) m = 1;
    if (m > REG_BYTES) m = REG_BYTES;
    if (m > MAX_MATCH_BYTES_DEF) m = MAX_MATCH_BYTES_DEF;
    return m;
  endfunction

  function automatic void drop_window(int unsigned k);
    if (k >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int j = 0; j < win_fill - k; j++) win[j] = win[j+k];
      win_fill = win_fill - k;
    end
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    out_item_t o;
    o = '0;
    o.out_valid = 1'b1;
    o.out_byte = b;
    step_out.push_back(o);
  endfunction

  // work out the output bytes caused by one source byte
  function automatic void replace_step(in_item_t req);
    int unsigned len;
    int unsigned rlen;
    logic        hit;
    logic        stop;
    logic [7:0]  head;
    out_item_t   o;
    step_out.delete();
    if (win_fill == 0) latched_len = eff_match_len();
    len = latched_len;
    if (win_fill < WINDOW_DEPTH) begin
      win[win_fill] = req.source_byte;
      win_fill++;
    end
    stop = 1'b0;
    while (win_fill > 0 && !stop) begin
      head = win[0];
      if (pass_next) begin
        emit_byte(head);
        drop_window(1);
        pass_next = 1'b0;
      end else if (win_fill < len && !req.end_of_text) begin
        stop = 1'b1;
      end else begin
        hit = (win_fill >= len);
        for (int k = 0; k < len && hit; k++) begin
          if (win[k] != pick_byte(regs_now.match_low_bytes, regs_now.match_high_bytes, k))
            hit = 1'b0;
        end
        if (hit) begin
          rlen = 32'(regs_now.replace_length);
          if (rlen > REG_BYTES) rlen = REG_BYTES;
          if (rlen > MAX_REPLACE_BYTES_DEF) rlen = MAX_REPLACE_BYTES_DEF;
          for (int k = 0; k < rlen; k++)
            emit_byte(pick_byte(regs_now.replace_low_bytes, regs_now.replace_high_bytes, k));
          drop_window(len);
          if (repl_total < COUNT_MAX) repl_total++;
        end else begin
          emit_byte(head);
          drop_window(1);
          if (head >= LEAD_LOW && (head <= LEAD_HIGH_END || head >= LEAD_HIGH_START))
            pass_next = 1'b1;
        end
      end
    end
    if (req.end_of_text) begin
      if (step_out.size() == 0) step_out.push_back('0);
      o = step_out[step_out.size()-1];
      o.out_last = 1'b1;
      o.replace_count = repl_total[15:0];
      step_out[step_out.size()-1] = o;
      win_fill = 0;
      repl_total = 0;
      pass_next = 1'b0;
    end
  endfunction

  function automatic void plan_req(logic [7:0] b, logic eot, logic typed = 1'b0,
                                   out_item_t want = '0);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.req.source_byte = b;
    r.req.end_of_text = eot;
    r.typed = typed;
    r.want = want;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_reg(logic [2:0] idx, logic [63:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    plan_q.push_back(r);
  endfunction

  function automatic void compare_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      failed = 1'b1;
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_MATCH_LOW:    regs_now.match_low_bytes = val;
      REG_MATCH_HIGH:   regs_now.match_high_bytes = val;
      REG_MATCH_LENGTH: regs_now.match_length = val[4:0];
      REG_REPLACE_LOW:  regs_now.replace_low_bytes = val;
      REG_REPLACE_HIGH: regs_now.replace_high_bytes = val;
      REG_REPLACE_LEN:  regs_now.replace_length = val[4:0];
      default: ;
    endcase
  endtask

  task automatic offer_request(in_item_t req, logic typed, out_item_t want);
    int unsigned gap;
    if (cfg_we_i) cfg_we_i <= 1'b0;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    replace_step(req);
    if (typed) awaited_q.push_back(want);
    else foreach (step_out[i]) awaited_q.push_back(step_out[i]);
  endtask

  // drain every awaited byte, then let the window logic go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned gap;
    out_item_t   got;
    out_item_t   want;
    logic        hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_wanted && !hold_done) begin
        res_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        res_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ready_i <= 1'b1;
      do @(posedge clk_i); while (!res_valid_o);
      got = res_item_o;
      if (awaited_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %p", $time, got);
        failed = 1'b1;
      end else begin
        want = awaited_q.pop_front();
        compare_field("out_valid", want.out_valid, got.out_valid);
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("out_last", want.out_last, got.out_last);
        compare_field("replace_count", want.replace_count, got.replace_count);
      end
    end
  end

  initial begin
    logic [7:0]  text_bytes [$];
    in_item_t    req;
    int unsigned sent_random;
    int unsigned phase_items;
    int unsigned phase;
    int unsigned text_len;
    int unsigned pick;
    int unsigned cut;
    int unsigned m_len;
    int unsigned r_len;
    logic [63:0] wdata;

    regs_now = '0;
    regs_now.match_length = 5'd1;
    win_fill = 0;
    latched_len = 1;
    repl_total = 0;
    pass_next = 1'b0;

    // reset values: match a single zero byte, replace with nothing
    plan_req(8'h41, 1'b1, 1'b1, {1'b1, 8'h41, 1'b1, 16'd0});
    plan_req(8'h00, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, 16'd1});
    plan_req(8'h81, 1'b1, 1'b1, {1'b1, 8'h81, 1'b1, 16'd0});
    plan_req(8'h00, 1'b0);
    plan_req(8'hFF, 1'b0);
    plan_req(8'h00, 1'b0);
    plan_req(8'h80, 1'b0);
    plan_req(8'h9F, 1'b0);
    plan_req(8'hA0, 1'b0);
    plan_req(8'hDF, 1'b0);
    plan_req(8'hE0, 1'b1);
    plan_reg(REG_UNMAPPED, '1);
    plan_req(8'h00, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1, 16'd1});
    plan_reg(REG_MATCH_LOW, 64'h4241);
    plan_reg(REG_MATCH_LENGTH, 64'd0);
    plan_reg(REG_REPLACE_LOW, 64'h7978);
    plan_reg(REG_REPLACE_LEN, 64'd2);
    plan_req(8'h41, 1'b0);
    plan_req(8'h42, 1'b1);
    plan_reg(REG_MATCH_LENGTH, 64'd2);
    plan_reg(REG_REPLACE_LEN, 64'd0);
    plan_req(8'h41, 1'b0);
    plan_req(8'h42, 1'b0);
    plan_req(8'h41, 1'b1);
    plan_reg(REG_MATCH_HIGH, '1);
    plan_reg(REG_MATCH_LENGTH, '1);
    plan_reg(REG_REPLACE_LOW, '1);
    plan_reg(REG_REPLACE_HIGH, 64'd0);
    plan_reg(REG_REPLACE_LEN, '1);
    plan_req(8'h41, 1'b0);
    plan_req(8'h42, 1'b0);
    plan_req(8'hE5, 1'b1);
    plan_reg(REG_MATCH_LENGTH, 64'd2);
    plan_reg(REG_REPLACE_LEN, 64'd1);
    plan_req(8'h41, 1'b0);
    plan_reg(REG_MATCH_LENGTH, 64'd1);
    plan_req(8'h42, 1'b0);
    plan_req(8'h41, 1'b1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_REG) begin
        if (i == 0 || plan_q[i-1].kind == ROW_REQ) settle();
        write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
      end else begin
        offer_request(plan_q[i].req, plan_q[i].typed, plan_q[i].want);
      end
    end

    sent_random = 0;
    for (phase = 0; sent_random < RANDOM_ITEMS; phase++) begin
      settle();
      case (phase % 4)
        0: begin
          m_len = 16;
          r_len = 16;
        end
        1: begin
          m_len = 1;
          r_len = 0;
        end
        2: begin
          m_len = $urandom_range(1, 16);
          r_len = $urandom_range(0, 16);
        end
        default: begin
          m_len = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
          r_len = $urandom_range(17, 31);
        end
      endcase
      write_reg(REG_MATCH_LOW, {$urandom, $urandom});
      write_reg(REG_MATCH_HIGH, {$urandom, $urandom});
      wdata = {$urandom, $urandom};
      wdata[4:0] = 5'(m_len);
      write_reg(REG_MATCH_LENGTH, wdata);
      write_reg(REG_REPLACE_LOW, {$urandom, $urandom});
      write_reg(REG_REPLACE_HIGH, {$urandom, $urandom});
      wdata = {$urandom, $urandom};
      wdata[4:0] = 5'(r_len);
      write_reg(REG_REPLACE_LEN, wdata);

      phase_items = 0;
      while (phase_items < PHASE_ITEMS && sent_random < RANDOM_ITEMS) begin
        text_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
        text_bytes.delete();
        while (text_bytes.size() < text_len) begin
          pick = $urandom_range(0, 99);
          if (pick < 35) begin
            cut = eff_match_len();
            if (pick < 8) cut = $urandom_range(1, cut);
            for (int k = 0; k < cut; k++)
              text_bytes.push_back(pick_byte(regs_now.match_low_bytes,
                                             regs_now.match_high_bytes, k));
          end else if (pick < 55) begin
            text_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range(129, 159)
                                                         : $urandom_range(224, 255)));
          end else if (pick < 70) begin
            text_bytes.push_back(regs_now.match_low_bytes[7:0]);
          end else begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        foreach (text_bytes[i]) begin
          req.source_byte = text_bytes[i];
          req.end_of_text = (i == text_bytes.size() - 1);
          offer_request(req, 1'b0, '0);
          sent_random++;
          phase_items++;
          if (sent_random == HOLD_AFTER) hold_wanted = 1'b1;
        end
      end
    end

    settle();
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
